@@ rtl/pst_pkg.sv @@
package pst_pkg;

  localparam int RAW_W    = 12;
  localparam int PH_W     = 16;
  localparam int TREND_W  = 17;
  localparam int CLASS_W  = 2;
  localparam int CNT_W    = 4;
  localparam int MUL_A_W  = 24;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int HISTORY_DEPTH_DEF = 8;

  // Q4.12 constants
  localparam logic [PH_W-1:0] PH_SEVEN  = 16'd28672;
  localparam logic [PH_W-1:0] PH_POT_LO = 16'd26624;
  localparam logic [PH_W-1:0] PH_POT_HI = 16'd34816;
  localparam logic [PH_W-1:0] PH_COR_LO = 16'd22528;
  localparam logic [PH_W-1:0] PH_COR_HI = 16'd38912;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  // ceil(2^19 / 3): exact divide by three for sums below 2^19
  localparam logic [MUL_B_W-1:0] RECIP3 = 18'd174763;
  localparam int RECIP3_SHIFT = 19;

  localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PER_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMP  = 3'd5;

  localparam logic [CLASS_W-1:0] CLASS_POTABLE   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_CORRECT   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_EMERGENCY = 2'd2;

  typedef struct packed {
    logic [19:0]      ph_intercept;
    logic [23:0]      ph_per_count;
    logic [PH_W-1:0]  ph_floor;
    logic [PH_W-1:0]  ph_ceiling;
    logic [16:0]      smoothing_weight;
    logic [CNT_W-1:0] trend_min_samples;
  } pst_cfg_t;

  function automatic logic [CLASS_W-1:0] classify(input logic [PH_W-1:0] ph);
    logic [CLASS_W-1:0] c;
    if (ph >= PH_POT_LO && ph <= PH_POT_HI) c = CLASS_POTABLE;
    else if (ph >= PH_COR_LO && ph <= PH_COR_HI) c = CLASS_CORRECT;
    else c = CLASS_EMERGENCY;
    return c;
  endfunction

endpackage

@@ rtl/pst_cfg.sv @@
module pst_cfg import pst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output pst_cfg_t              cfg
);

  pst_cfg_t cfg_r;
  pst_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_INTERCEPT: cfg_nxt.ph_intercept      = wr_data[19:0];
        REG_PER_COUNT: cfg_nxt.ph_per_count      = wr_data[23:0];
        REG_FLOOR:     cfg_nxt.ph_floor          = wr_data[PH_W-1:0];
        REG_CEILING:   cfg_nxt.ph_ceiling        = wr_data[PH_W-1:0];
        REG_WEIGHT:    cfg_nxt.smoothing_weight  = wr_data[16:0];
        REG_MIN_SAMP:  cfg_nxt.trend_min_samples = wr_data[CNT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ph_intercept      <= 20'd85561;
      cfg_r.ph_per_count      <= 24'd75093;
      cfg_r.ph_floor          <= 16'd0;
      cfg_r.ph_ceiling        <= 16'd57344;
      cfg_r.smoothing_weight  <= 17'd6554;
      cfg_r.trend_min_samples <= 4'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/pst_mul.sv @@
module pst_mul import pst_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [MUL_A_W-1:0] op_a,
  input  logic [MUL_B_W-1:0] op_b,
  output logic [PROD_W-1:0]  prod
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  assign prod = prod_r;

endmodule

@@ rtl/ph_sample_smoother_trend_unit.sv @@
// pH sample smoother with trend.
// in_*  : one raw 12-bit converter reading per transaction (in_tdata[11:0]).
// out_* : one result per input: calibrated pH, updated moving average, trend,
//         trend-updated flag and water class.
// cfg_* : register writes by index; cfg_ready is always high. Write only while idle.
// A sample is accepted in the idle state; it then passes four sequencer steps
// that share a single 24x18 multiplier (conversion, old-average term,
// new-sample term, divide by three), so a result is loaded into the output
// register as the sequencer leaves its last step, and the next sample can be
// taken once it is back in the idle state: a new sample is accepted only after
// the previous one has made all four passes through the shared multiplier.
// The output register lets the next sample be accepted while a result waits.
// When the receiver stalls and a new result is finished, the sequencer holds
// in its last step until the output register frees up.
// Synchronous reset (rst_n low) restores the register defaults, sets the
// average to pH 7.0, clears the history, sample count and trend, and empties
// the output register.
module ph_sample_smoother_trend_unit import pst_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [11:0] raw_sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata,  // [15:0] ph_now, [31:16] ph_smoothed,
                                            // [48:32] ph_trend, [49] trend_ready,
                                            // [51:50] water_class
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_OLD  = 5'b00010,
    S_NEW  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  pst_cfg_t cfg;
  state_t   state_r, state_nxt;

  logic [MUL_A_W-1:0] op_a;
  logic [MUL_B_W-1:0] op_b;
  logic [PROD_W-1:0]  prod;
  logic               mul_en;

  logic [PH_W-1:0]    ph_r;
  logic [PH_W-1:0]    avg_r;
  logic [PH_W-1:0]    hist_r [3];
  logic [CNT_W-1:0]   cnt_r;
  logic signed [TREND_W-1:0] trend_r;
  logic [31:0]        acc_r;
  logic [17:0]        sum_r;

  logic               out_valid_r;
  logic [55:0]        out_data_r;

  logic [16:0]        w_eff;
  logic [16:0]        w_rest;
  logic signed [24:0] ph_diff;
  logic [PH_W-1:0]    ph_clamp;
  logic [32:0]        avg_sum;
  logic [PH_W-1:0]    mean;
  logic               upd;
  logic signed [TREND_W-1:0] trend_val;
  logic               accept;
  logic               fin_go;

  pst_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pst_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_tready);

  assign w_eff  = (cfg.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.smoothing_weight;
  assign w_rest = WEIGHT_ONE - w_eff;

  // intercept minus truncated product, signed, then clamp with floor first
  assign ph_diff = $signed({5'd0, cfg.ph_intercept}) - $signed({1'b0, prod[35:12]});
  always_comb begin
    if (ph_diff < $signed({9'd0, cfg.ph_floor})) ph_clamp = cfg.ph_floor;
    else if (ph_diff > $signed({9'd0, cfg.ph_ceiling})) ph_clamp = cfg.ph_ceiling;
    else ph_clamp = ph_diff[PH_W-1:0];
  end

  assign avg_sum   = {1'b0, acc_r} + {1'b0, prod[31:0]};
  assign mean      = prod[RECIP3_SHIFT+PH_W-1:RECIP3_SHIFT];
  assign upd       = (cnt_r >= cfg.trend_min_samples);
  assign trend_val = $signed({1'b0, mean}) - $signed({1'b0, avg_r});

  // shared multiplier operand selection
  always_comb begin
    op_a   = cfg.ph_per_count;
    op_b   = {{(MUL_B_W-RAW_W){1'b0}}, in_tdata[RAW_W-1:0]};
    mul_en = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        op_a = cfg.ph_per_count;
        op_b = {{(MUL_B_W-RAW_W){1'b0}}, in_tdata[RAW_W-1:0]};
      end
      S_OLD: begin
        op_a = {7'd0, w_rest};
        op_b = {2'd0, avg_r};
      end
      S_NEW: begin
        op_a = {7'd0, w_eff};
        op_b = {2'd0, ph_r};
      end
      S_DIV: begin
        op_a = {6'd0, sum_r};
        op_b = RECIP3;
      end
      S_FIN: begin
        mul_en = 1'b0;  // hold the quotient while stalled
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_OLD;
      S_OLD:   state_nxt = S_NEW;
      S_NEW:   state_nxt = S_DIV;
      S_DIV:   state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      avg_r       <= PH_SEVEN;
      hist_r[0]   <= '0;
      hist_r[1]   <= '0;
      hist_r[2]   <= '0;
      cnt_r       <= '0;
      trend_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DIV) begin
        avg_r     <= avg_sum[31:16];
        hist_r[0] <= hist_r[1];
        hist_r[1] <= hist_r[2];
        hist_r[2] <= ph_r;
        if (cnt_r < CNT_W'(HISTORY_DEPTH)) cnt_r <= cnt_r + CNT_W'(1);
      end
      // load a finished result, otherwise drop the flag once taken
      if (fin_go) begin
        out_valid_r <= 1'b1;
        if (upd) trend_r <= trend_val;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_OLD) ph_r <= ph_clamp;
    if (state_r == S_NEW) begin
      acc_r <= prod[31:0];
      sum_r <= {2'd0, hist_r[1]} + {2'd0, hist_r[2]} + {2'd0, ph_r};
    end
    if (fin_go) begin
      out_data_r <= {4'd0, classify(ph_r), upd, (upd ? trend_val : trend_r), avg_r, ph_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
